@@ rtl/core/sha256h_pkg.sv @@
package sha256h_pkg;

    // Input action codes (carried on s_tuser)
    localparam logic [1:0] ACT_ABSORB        = 2'd0;
    localparam logic [1:0] ACT_ABSORB_FINISH = 2'd1;
    localparam logic [1:0] ACT_FINISH        = 2'd2;

    // Padding constants
    localparam logic [7:0] PAD_MARKER = 8'h80;
    localparam logic [7:0] PAD_ZERO   = 8'h00;
    localparam logic [5:0] LEN_POS    = 6'd56;
    localparam logic [5:0] BLOCK_LAST = 6'd63;
    localparam logic [5:0] ROUND_LAST = 6'd63;
    localparam logic [2:0] WORD_LAST  = 3'd7;
    localparam logic [63:0] BYTE_BITS = 64'd8;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_START,
        ST_ROUND,
        ST_FOLD,
        ST_EMIT
    } state_t;

    // Schedule window controls
    typedef struct packed {
        logic       load_byte;
        logic [7:0] load_val;
        logic       shift_word;
    } sched_ctl_t;

    // Round unit controls
    typedef struct packed {
        logic       init_vars;
        logic       step;
        logic       fold;
        logic       emit_shift;
        logic [2:0] emit_idx;
    } rnd_ctl_t;

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] big_sig0(input logic [31:0] x);
        big_sig0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sig1(input logic [31:0] x);
        big_sig1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small_sig0(input logic [31:0] x);
        small_sig0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sig1(input logic [31:0] x);
        small_sig1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
    endfunction

endpackage

@@ rtl/core/sha256h_sched.sv @@
module sha256h_sched (
    input  logic                    aclk,
    input  sha256h_pkg::sched_ctl_t ctl,
    output logic [31:0]             w_cur
);
    import sha256h_pkg::*;

    // Block bytes and message schedule share one 512-bit window.
    // Word 0 sits in the top 32 bits.
    logic [511:0] win_reg;
    logic [511:0] win_next;
    logic [31:0]  w_new;

    // Next schedule word: W[t+16] from W[t], W[t+1], W[t+9], W[t+14]
    assign w_new = small_sig1(win_reg[511-32*14 -: 32]) + win_reg[511-32*9 -: 32]
                 + small_sig0(win_reg[511-32*1 -: 32]) + win_reg[511 -: 32];

    assign w_cur = win_reg[511 -: 32];

    always_comb begin
        win_next = win_reg;
        if (ctl.load_byte) begin
            win_next = {win_reg[503:0], ctl.load_val};
        end else if (ctl.shift_word) begin
            win_next = {win_reg[479:0], w_new};
        end
    end

    always_ff @(posedge aclk) begin
        win_reg <= win_next;
    end

endmodule

@@ rtl/core/sha256h_round.sv @@
module sha256h_round (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  sha256h_pkg::rnd_ctl_t ctl,
    input  logic [31:0]           round_k,
    input  logic [31:0]           w_cur,
    output logic [31:0]           digest_word
);
    import sha256h_pkg::*;

    logic [31:0] chain_reg [8];
    logic [31:0] chain_next [8];
    logic [31:0] var_reg [8];
    logic [31:0] var_next [8];
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] ch_val;
    logic [31:0] maj_val;

    // One compression round
    assign ch_val  = (var_reg[4] & var_reg[5]) ^ (~var_reg[4] & var_reg[6]);
    assign maj_val = (var_reg[0] & var_reg[1]) ^ (var_reg[0] & var_reg[2])
                   ^ (var_reg[1] & var_reg[2]);
    assign t1 = var_reg[7] + big_sig1(var_reg[4]) + ch_val + round_k + w_cur;
    assign t2 = big_sig0(var_reg[0]) + maj_val;

    assign digest_word = chain_reg[0];

    // Working variables
    always_comb begin
        var_next = var_reg;
        if (ctl.init_vars) begin
            var_next = chain_reg;
        end else if (ctl.step) begin
            var_next[7] = var_reg[6];
            var_next[6] = var_reg[5];
            var_next[5] = var_reg[4];
            var_next[4] = var_reg[3] + t1;
            var_next[3] = var_reg[2];
            var_next[2] = var_reg[1];
            var_next[1] = var_reg[0];
            var_next[0] = t1 + t2;
        end
    end

    // Chaining words: fold after a block, shift out and reload IV during output
    always_comb begin
        chain_next = chain_reg;
        if (ctl.fold) begin
            for (int i = 0; i < 8; i++) begin
                chain_next[i] = chain_reg[i] + var_reg[i];
            end
        end else if (ctl.emit_shift) begin
            for (int i = 0; i < 7; i++) begin
                chain_next[i] = chain_reg[i+1];
            end
            chain_next[7] = INIT_HASH[ctl.emit_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chain_reg <= INIT_HASH;
        end else begin
            chain_reg <= chain_next;
        end
    end

    always_ff @(posedge aclk) begin
        var_reg <= var_next;
    end

endmodule

@@ rtl/core/sha256_byte_stream_hasher.sv @@
// SHA-256 over a byte stream. Each s_ transaction carries one message byte
// (action absorb), one byte followed by finish, or a bare finish; action code
// 3 is dropped. Bytes are taken only in the idle state; the 64th byte of a block
// starts a compression (load, 64 rounds in the single round unit, fold into
// the chaining words) with s_tready low. Finish appends the 0x80
// marker, zeros and the 64-bit bit length one byte per cycle, with one or
// two compressions, then sends the digest as eight 32-bit m_ transactions,
// most significant word first, m_tlast on the eighth. The initial hash value
// is reloaded as the words leave, so the next message can follow at once.
module sha256_byte_stream_hasher (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [1:0]  s_tuser,   // [1:0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] digest_word
    output logic        m_tlast    // word_last
);
    import sha256h_pkg::*;

    state_t      state_reg, state_next;
    logic [5:0]  fill_reg, fill_next;
    logic [63:0] bits_reg, bits_next;
    logic        fin_reg, fin_next;
    logic        marker_reg, marker_next;
    logic        len_ok_reg, len_ok_next;
    logic        len_done_reg, len_done_next;
    logic [5:0]  rnd_reg, rnd_next;
    logic [2:0]  emit_reg, emit_next;

    logic        s_acc;
    logic        m_acc;
    logic        act_byte;
    logic        act_fin;
    logic        load;
    logic [5:0]  len_shamt;
    logic [7:0]  len_byte;
    logic [7:0]  pad_byte;
    logic [31:0] digest_word;

    sched_ctl_t  sched_ctl;
    rnd_ctl_t    rnd_ctl;
    logic [31:0] w_cur;

    assign s_acc    = s_tvalid && s_tready;
    assign m_acc    = m_tvalid && m_tready;
    assign act_byte = s_acc && (s_tuser == ACT_ABSORB || s_tuser == ACT_ABSORB_FINISH);
    assign act_fin  = s_acc && (s_tuser == ACT_ABSORB_FINISH || s_tuser == ACT_FINISH);
    assign load     = act_byte || (state_reg == ST_PAD);

    // Length byte for block positions 56..63, most significant first
    assign len_shamt = {~fill_reg[2:0], 3'b000};
    assign len_byte  = 8'(bits_reg >> len_shamt);

    always_comb begin
        if (!marker_reg) begin
            pad_byte = PAD_MARKER;
        end else if (len_ok_reg && fill_reg >= LEN_POS) begin
            pad_byte = len_byte;
        end else begin
            pad_byte = PAD_ZERO;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (act_byte && fill_reg == BLOCK_LAST) begin
                    state_next = ST_START;
                end else if (act_fin) begin
                    state_next = ST_PAD;
                end
            end
            ST_PAD: begin
                if (fill_reg == BLOCK_LAST) begin
                    state_next = ST_START;
                end
            end
            ST_START: state_next = ST_ROUND;
            ST_ROUND: begin
                if (rnd_reg == ROUND_LAST) begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD: begin
                if (!fin_reg) begin
                    state_next = ST_IDLE;
                end else if (len_done_reg) begin
                    state_next = ST_EMIT;
                end else begin
                    state_next = ST_PAD;
                end
            end
            ST_EMIT: begin
                if (m_acc && emit_reg == WORD_LAST) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs and datapath controls
    always_comb begin
        s_tready             = 1'b0;
        m_tvalid             = 1'b0;
        sched_ctl.load_byte  = load;
        sched_ctl.load_val   = (state_reg == ST_PAD) ? pad_byte : s_tdata;
        sched_ctl.shift_word = 1'b0;
        rnd_ctl.init_vars    = 1'b0;
        rnd_ctl.step         = 1'b0;
        rnd_ctl.fold         = 1'b0;
        rnd_ctl.emit_shift   = 1'b0;
        rnd_ctl.emit_idx     = emit_reg;
        case (state_reg)
            ST_IDLE:  s_tready = 1'b1;
            ST_PAD:   ;
            ST_START: rnd_ctl.init_vars = 1'b1;
            ST_ROUND: begin
                rnd_ctl.step         = 1'b1;
                sched_ctl.shift_word = 1'b1;
            end
            ST_FOLD:  rnd_ctl.fold = 1'b1;
            ST_EMIT: begin
                m_tvalid           = 1'b1;
                rnd_ctl.emit_shift = m_tready;
            end
            default: ;
        endcase
    end

    assign m_tdata = digest_word;
    assign m_tlast = (emit_reg == WORD_LAST);

    // Counters and padding flags
    always_comb begin
        fill_next     = fill_reg;
        bits_next     = bits_reg;
        fin_next      = fin_reg;
        marker_next   = marker_reg;
        len_ok_next   = len_ok_reg;
        len_done_next = len_done_reg;
        rnd_next      = rnd_reg;
        emit_next     = emit_reg;

        if (load) begin
            fill_next = fill_reg + 6'd1;
        end
        if (act_byte) begin
            bits_next = bits_reg + BYTE_BITS;
        end
        if (act_fin) begin
            fin_next = 1'b1;
        end
        if (state_reg == ST_PAD) begin
            if (!marker_reg) begin
                marker_next = 1'b1;
                len_ok_next = (fill_reg < LEN_POS);
            end else if (len_ok_reg && fill_reg == BLOCK_LAST) begin
                len_done_next = 1'b1;
            end
        end
        // A fresh block after the marker always has room for the length
        if (state_reg == ST_FOLD && fin_reg && marker_reg) begin
            len_ok_next = 1'b1;
        end
        if (state_reg == ST_START) begin
            rnd_next = '0;
        end else if (state_reg == ST_ROUND) begin
            rnd_next = rnd_reg + 6'd1;
        end
        if (m_acc) begin
            emit_next = emit_reg + 3'd1;
            if (emit_reg == WORD_LAST) begin
                fill_next     = '0;
                bits_next     = '0;
                fin_next      = 1'b0;
                marker_next   = 1'b0;
                len_ok_next   = 1'b0;
                len_done_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            fill_reg     <= '0;
            bits_reg     <= '0;
            fin_reg      <= 1'b0;
            marker_reg   <= 1'b0;
            len_ok_reg   <= 1'b0;
            len_done_reg <= 1'b0;
            rnd_reg      <= '0;
            emit_reg     <= '0;
        end else begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            bits_reg     <= bits_next;
            fin_reg      <= fin_next;
            marker_reg   <= marker_next;
            len_ok_reg   <= len_ok_next;
            len_done_reg <= len_done_next;
            rnd_reg      <= rnd_next;
            emit_reg     <= emit_next;
        end
    end

    sha256h_sched u_sched (
        .aclk  (aclk),
        .ctl   (sched_ctl),
        .w_cur (w_cur)
    );

    sha256h_round u_round (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctl         (rnd_ctl),
        .round_k     (ROUND_K[rnd_reg]),
        .w_cur       (w_cur),
        .digest_word (digest_word)
    );

endmodule
